FILE: rtl/core/ir_distance_averager_macros.svh
// assertion macros for the ir distance averager
`ifndef IR_DISTANCE_AVERAGER_MACROS_SVH
`define IR_DISTANCE_AVERAGER_MACROS_SVH

`ifndef SYNTH
`define IDA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ida assertion failed");
`define IDA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ida assertion failed");
`else
`define IDA_ASSERT(lbl, prop)
`define IDA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/ida_pkg.sv
`timescale 1ns / 1ps
package ida_pkg;

	localparam int NUM_SAMPLES = 5;
	localparam int SAMPLE_BITS = 10;
	localparam int CFG_W       = 16;
	localparam int DIST_W      = 17;
	localparam int CFG_IDX_W   = 2;

	localparam int IDX_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
	localparam int SUM_MAX = NUM_SAMPLES * ((1 << SAMPLE_BITS) - 1);
	localparam int SUM_W = $clog2(SUM_MAX + 1);

	// conversion: d = (CONV_NUM - 248*D) div (10*D), D = sum + NUM_SAMPLES
	localparam int CONV_NUM    = 930000 * NUM_SAMPLES;
	localparam int CONV_OFFSET = 248;
	localparam int CONV_SCALE  = 10;
	localparam int D_MAX  = SUM_MAX + NUM_SAMPLES;
	localparam int NUM_W  = $clog2(CONV_NUM + 1);
	localparam int DEN_W  = $clog2(CONV_SCALE * D_MAX + 1);
	localparam int WIDE_W = $clog2(CONV_OFFSET * D_MAX + CONV_NUM + 1) + 1;
	localparam int CNT_W  = $clog2(NUM_W + 1);
	localparam int DIST_MAX = (1 << DIST_W) - 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEASURE_INTERVAL = 2'd0,
		CFG_NOTIFY_ENABLE    = 2'd1,
		CFG_NOTIFY_EVERY     = 2'd2
	} cfg_idx_t;

endpackage

FILE: rtl/core/ida_if.sv
`timescale 1ns / 1ps
interface ida_in_if import ida_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface ida_out_if import ida_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance_mm;
	logic              new_measure;
	logic              notify;

	modport source (output valid, output distance_mm, output new_measure, output notify,
		input ready);
	modport sink (input valid, input distance_mm, input new_measure, input notify,
		output ready);
endinterface

FILE: rtl/core/ida_serial_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module ida_serial_div import ida_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	logic [NUM_W-1:0] num_sh_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, num_sh_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_sh_q <= num;
			den_q    <= den;
			rem_q    <= '0;
			quot_q   <= '0;
		end else if (busy_q) begin
			num_sh_q <= {num_sh_q[NUM_W-2:0], 1'b0};
			quot_q   <= {quot_q[NUM_W-2:0], fits};
			rem_q    <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: rtl/core/ir_distance_averager.sv
`timescale 1ns / 1ps
// Moving-average distance converter for an analog infrared range sensor. Each input word is one
// tick carrying the current converter sample; each tick gives exactly one output word with the
// held distance in mm, a new_measure flag and a notify flag. A tick that does not start a
// measurement is answered in the next cycle. A measuring tick updates the five-entry sample
// ring and its running sum, then converts the sum with a bit-serial restoring divider that
// produces one quotient bit per cycle (zero for a negative numerator); no new tick is taken
// while the divider runs. The user must write registers through a plain write port while the
// block is idle (unenforced by the block): 0 measure_interval, 1 notify_enable, 2 notify_every.
`include "ir_distance_averager_macros.svh"
module ir_distance_averager import ida_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	ida_in_if.sink               in_ch,
	ida_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_WAIT,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]       interval_q;
	logic                   notify_en_q;
	logic [CFG_W-1:0]       notify_every_q;

	logic [CFG_W-1:0]       elapsed_q;
	logic [SAMPLE_BITS-1:0] ring_q [NUM_SAMPLES];
	logic [IDX_W-1:0]       idx_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CFG_W-1:0]       notify_cnt_q;
	logic [DIST_W-1:0]      held_q;
	logic                   pulse_q;

	logic                   out_valid_q;
	logic [DIST_W-1:0]      out_dist_q;
	logic                   out_new_q;
	logic                   out_notify_q;

	logic                   accept;
	logic                   out_free;
	logic [CFG_W-1:0]       elapsed_next;
	logic                   measure;
	logic [IDX_W-1:0]       idx_next;
	logic [SUM_W-1:0]       sum_next;
	logic [WIDE_W-1:0]      d_wide;
	logic [WIDE_W-1:0]      diff;
	logic [WIDE_W-1:0]      den_wide;
	logic                   div_start;
	logic                   div_done;
	logic [NUM_W-1:0]       div_quot;

	assign out_free     = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = (state_q == ST_IDLE) && out_free;
	assign accept       = in_ch.valid && in_ch.ready;

	always_comb begin
		elapsed_next = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
		measure      = elapsed_next >= interval_q;
		idx_next     = (idx_q == IDX_W'(NUM_SAMPLES - 1)) ? '0 : idx_q + 1'b1;
		// running sum: drop the entry being replaced, add the new sample
		sum_next     = sum_q - SUM_W'(ring_q[idx_next]) + SUM_W'(in_ch.adc_sample);
		d_wide       = WIDE_W'(sum_q) + WIDE_W'(NUM_SAMPLES);
		diff         = WIDE_W'(CONV_NUM) - WIDE_W'(CONV_OFFSET) * d_wide;
		den_wide     = WIDE_W'(CONV_SCALE) * d_wide;
		div_start    = (state_q == ST_PREP) && !diff[WIDE_W-1];
	end

	ida_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (diff[NUM_W-1:0]),
		.den    (den_wide[DEN_W-1:0]),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q     <= CFG_W'(30);
			notify_en_q    <= 1'b0;
			notify_every_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MEASURE_INTERVAL: interval_q     <= cfg_wdata;
				CFG_NOTIFY_ENABLE:    notify_en_q    <= cfg_wdata[0];
				CFG_NOTIFY_EVERY:     notify_every_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SAMPLES; i++) begin
				ring_q[i] <= '0;
			end
		end else if (accept && measure) begin
			ring_q[idx_next] <= in_ch.adc_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			elapsed_q    <= '0;
			idx_q        <= '0;
			sum_q        <= '0;
			notify_cnt_q <= '0;
			held_q       <= '0;
			pulse_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_dist_q   <= '0;
			out_new_q    <= 1'b0;
			out_notify_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (measure) begin
							elapsed_q <= '0;
							idx_q     <= idx_next;
							sum_q     <= sum_next;
							pulse_q   <= 1'b0;
							if (notify_en_q) begin
								if (notify_cnt_q >= notify_every_q) begin
									notify_cnt_q <= '0;
									pulse_q      <= 1'b1;
								end else begin
									notify_cnt_q <= notify_cnt_q + 1'b1;
								end
							end
							state_q <= ST_PREP;
						end else begin
							elapsed_q    <= elapsed_next;
							out_valid_q  <= 1'b1;
							out_dist_q   <= held_q;
							out_new_q    <= 1'b0;
							out_notify_q <= 1'b0;
						end
					end
				end
				ST_PREP: begin
					// a negative numerator saturates the distance at zero
					if (diff[WIDE_W-1]) begin
						held_q  <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (div_done) begin
						held_q  <= (div_quot > NUM_W'(DIST_MAX)) ? DIST_W'(DIST_MAX)
							: div_quot[DIST_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_dist_q   <= held_q;
						out_new_q    <= 1'b1;
						out_notify_q <= pulse_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.distance_mm = out_dist_q;
	assign out_ch.new_measure = out_new_q;
	assign out_ch.notify      = out_notify_q;

	`IDA_ASSERT(a_busy_not_ready, (state_q == ST_IDLE) || !in_ch.ready)
	`IDA_ASSERT(a_div_done_in_wait, !div_done || (state_q == ST_WAIT))
	`IDA_ASSERT(a_notify_needs_measure, !out_valid_q || out_new_q || !out_notify_q)
	`IDA_ASSERT_NEXT(a_measure_leaves_idle, accept && measure, state_q == ST_PREP)

endmodule

FILE: tb/sv/tb_ir_distance_averager.sv
`timescale 1ns / 1ps
module tb_ir_distance_averager;
	import ida_pkg::*;

	localparam int SCRIPT_LEN      = 32;
	localparam int RAND_PHASES     = 10;
	localparam int TICKS_PER_PHASE = 117;
	localparam int LONG_TICKS      = 60;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT  = 5000;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              fresh;
		logic              notify;
	} reading_t;

	typedef struct packed {
		logic                   is_write;
		cfg_idx_t               reg_idx;
		logic [CFG_W-1:0]       reg_val;
		logic [SAMPLE_BITS-1:0] smp;
		logic                   typed;
		reading_t               want;
	} script_row_t;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	cfg_idx_t       cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	ida_in_if  tick_ch ();
	ida_out_if reading_ch ();

	ir_distance_averager i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (tick_ch),
		.out_ch   (reading_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// predictor copy of registers and state
	logic [CFG_W-1:0]       p_interval;
	logic                   p_notify_en;
	logic [CFG_W-1:0]       p_every;
	logic [15:0]            p_elapsed;
	logic [15:0]            p_notify_cnt;
	logic [SAMPLE_BITS-1:0] p_ring [NUM_SAMPLES];
	int unsigned            p_slot;
	logic [DIST_W-1:0]      p_held;

	reading_t pending_readings [$];
	int       error_count;
	int       stall_cycles;
	int       burst_left;
	bit       gaps_on;
	bit       hold_off_req;

	// typed rows: after reset, full-scale sums and the every-measurement pulse
	script_row_t script [SCRIPT_LEN] = '{
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd0,    1'b1, '{17'd0,     1'b0, 1'b0}},
		'{1'b1, CFG_MEASURE_INTERVAL, 16'd1,     10'd0,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd0,    1'b1, '{17'd92975, 1'b1, 1'b0}},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd1023, 1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd1023, 1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd1023, 1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd1023, 1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd1023, 1'b1, '{17'd66,    1'b1, 1'b0}},
		'{1'b1, CFG_NOTIFY_ENABLE,    16'd1,     10'd0,    1'b0, '0},
		'{1'b1, CFG_NOTIFY_EVERY,     16'd0,     10'd0,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd1023, 1'b1, '{17'd66,    1'b1, 1'b1}},
		'{1'b1, CFG_NOTIFY_EVERY,     16'd2,     10'd0,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'h2AA,  1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'h155,  1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'h3FF,  1'b0, '0},
		'{1'b1, CFG_NOTIFY_EVERY,     16'd3,     10'd0,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd0,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd0,    1'b0, '0},
		'{1'b1, CFG_NOTIFY_EVERY,     16'd0,     10'd0,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd512,  1'b0, '0},
		'{1'b1, CFG_NOTIFY_ENABLE,    16'd0,     10'd0,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd1,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd1022, 1'b0, '0},
		'{1'b1, CFG_MEASURE_INTERVAL, 16'd0,     10'd0,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd7,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd1000, 1'b0, '0},
		'{1'b1, CFG_MEASURE_INTERVAL, 16'hFFFF,  10'd0,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd300,  1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd301,  1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd302,  1'b0, '0},
		'{1'b1, CFG_MEASURE_INTERVAL, 16'd2,     10'd0,    1'b0, '0},
		'{1'b0, CFG_MEASURE_INTERVAL, 16'd0,     10'd33,   1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic reading_t predict_reading(logic [SAMPLE_BITS-1:0] smp);
		reading_t    r;
		int unsigned total;
		int unsigned quo;
		int          k;
		r = '0;
		if (p_elapsed != 16'hFFFF)
			p_elapsed++;
		if (p_elapsed >= p_interval) begin
			p_elapsed = '0;
			p_slot = (p_slot + 1) % NUM_SAMPLES;
			p_ring[p_slot] = smp;
			total = 0;
			for (k = 0; k < NUM_SAMPLES; k++)
				total += p_ring[k];
			quo = CONV_NUM / (total + NUM_SAMPLES);
			if (quo < CONV_OFFSET) begin
				p_held = '0;
			end else begin
				quo = (quo - CONV_OFFSET) / CONV_SCALE;
				p_held = (quo > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(quo);
			end
			r.fresh = 1'b1;
			if (p_notify_en) begin
				if (p_notify_cnt >= p_every) begin
					p_notify_cnt = '0;
					r.notify = 1'b1;
				end else begin
					p_notify_cnt++;
				end
			end
		end
		r.distance = p_held;
		return r;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
		endcase
	endfunction

	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MEASURE_INTERVAL: p_interval = val;
			CFG_NOTIFY_ENABLE:    p_notify_en = val[0];
			CFG_NOTIFY_EVERY:     p_every = val;
			default: ;
		endcase
	endtask

	task automatic send_tick(logic [SAMPLE_BITS-1:0] smp, logic typed, reading_t typed_val);
		int       gap;
		reading_t r;
		if (burst_left == 0) begin
			gap = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 12) : 0;
			if (gap != 0) begin
				tick_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		tick_ch.valid      <= 1'b1;
		tick_ch.adc_sample <= smp;
		do
			@(posedge clk);
		while (!tick_ch.ready);
		r = predict_reading(smp);
		pending_readings.push_back(typed ? typed_val : r);
	endtask

	// receiver pacing, with an occasional long hold-off on request
	initial begin : rx_pacing
		int run_len;
		int style;
		int k;
		reading_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				reading_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				run_len = $urandom_range(1, 40);
				style = $urandom_range(0, 3);
				for (k = 0; k < run_len; k++) begin
					case (style)
						0: reading_ch.ready <= 1'b1;
						1: reading_ch.ready <= ($urandom_range(0, 3) != 0);
						2: reading_ch.ready <= 1'($urandom_range(0, 1));
						default: reading_ch.ready <= (k % 3 != 2);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : reading_check
		reading_t want;
		if (arst_n && reading_ch.valid && reading_ch.ready) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected word distance_mm %0d new_measure %0b notify %0b",
					$time, reading_ch.distance_mm, reading_ch.new_measure, reading_ch.notify);
				error_count++;
			end else begin
				want = pending_readings.pop_front();
				if (reading_ch.distance_mm !== want.distance) begin
					$display("%0t: distance_mm expected %0d got %0d",
						$time, want.distance, reading_ch.distance_mm);
					error_count++;
				end
				if (reading_ch.new_measure !== want.fresh) begin
					$display("%0t: new_measure expected %0b got %0b",
						$time, want.fresh, reading_ch.new_measure);
					error_count++;
				end
				if (reading_ch.notify !== want.notify) begin
					$display("%0t: notify expected %0b got %0b",
						$time, want.notify, reading_ch.notify);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (tick_ch.valid && tick_ch.ready) || (reading_ch.valid && reading_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles == WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int row;
		int phase;
		int n;
		tick_ch.valid      <= 1'b0;
		tick_ch.adc_sample <= '0;
		cfg_we             <= 1'b0;
		cfg_idx            <= CFG_MEASURE_INTERVAL;
		cfg_wdata          <= '0;
		arst_n             <= 1'b0;
		error_count  = 0;
		stall_cycles = 0;
		burst_left   = 0;
		gaps_on      = 1'b1;
		hold_off_req = 1'b0;
		p_interval   = 16'd30;
		p_notify_en  = 1'b0;
		p_every      = 16'd1;
		p_elapsed    = '0;
		p_notify_cnt = '0;
		p_slot       = 0;
		p_held       = '0;
		for (n = 0; n < NUM_SAMPLES; n++)
			p_ring[n] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < SCRIPT_LEN; row++) begin
			if (script[row].is_write)
				write_reg(script[row].reg_idx, script[row].reg_val);
			else
				send_tick(script[row].smp, script[row].typed, script[row].want);
		end

		// largest interval: a long run of back-to-back ticks with no measurement
		write_reg(CFG_MEASURE_INTERVAL, 16'hFFFF);
		gaps_on = 1'b0;
		repeat (LONG_TICKS) send_tick(pick_sample(), 1'b0, '0);
		gaps_on = 1'b1;

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase == 1) begin
				write_reg(CFG_NOTIFY_ENABLE, 16'd1);
				write_reg(CFG_NOTIFY_EVERY, 16'hFFFF);
			end else begin
				if ($urandom_range(0, 2) != 0)
					write_reg(CFG_MEASURE_INTERVAL, ($urandom_range(0, 9) < 7) ?
						CFG_W'($urandom_range(0, 4)) : CFG_W'($urandom_range(5, 40)));
				if ($urandom_range(0, 2) != 0)
					write_reg(CFG_NOTIFY_ENABLE, CFG_W'($urandom_range(0, 16'hFFFF)));
				if ($urandom_range(0, 2) != 0)
					write_reg(CFG_NOTIFY_EVERY, ($urandom_range(0, 9) != 0) ?
						CFG_W'($urandom_range(0, 3)) : CFG_W'($urandom_range(4, 16'hFFFF)));
			end
			// output blocked for a long stretch while ticks keep coming
			if (phase == 2)
				hold_off_req = 1'b1;
			for (n = 0; n < TICKS_PER_PHASE; n++) begin
				if (phase == 4 && n == TICKS_PER_PHASE / 2)
					wait_drained();
				send_tick(pick_sample(), 1'b0, '0);
			end
		end

		wait_drained();
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ida_pkg.sv
rtl/core/ida_if.sv
rtl/core/ida_serial_div.sv
rtl/core/ir_distance_averager.sv
tb/sv/tb_ir_distance_averager.sv
